// ===== rtl/ftoi_pkg.sv =====
// ftoi_pkg: request/response types and mode codes for the float to integer converter.
// No dependencies.
package ftoi_pkg;

   typedef enum logic [1:0] {
      MODE_BYTE   = 2'd0,
      MODE_SSHORT = 2'd1,
      MODE_USHORT = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   localparam logic CSR_OUT_MODE     = 1'b0;
   localparam logic CSR_SIGNED_BYTES = 1'b1;

   typedef struct packed {
      logic [31:0] sample_bits;
      logic        last_in_line;
   } req_type;

   typedef struct packed {
      logic [15:0] converted;
      logic        clipped;
      logic        last_out;
   } rsp_type;

endpackage

// ===== rtl/float_to_int_saturating_convert.sv =====
// float_to_int_saturating_convert: float32 sample to saturated 8/16-bit integer.
// Depends on ftoi_pkg.
//
//   channel | ports                          | handshake
//   req     | req_start, req_busy, req_data  | accepted when start and !busy
//   rsp     | rsp_strobe, rsp_data           | one cycle, no backpressure
//   csr     | csr_valid, csr_ready, csr_index, csr_data | valid and ready
//
// One request per cycle. The result passes through the input register, then the result
// register, before it sits on the rsp ports.
// busy is held low, so there are no stalls.
// Synchronous active-high reset clears valid flags and the csr registers.
module float_to_int_saturating_convert (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  ftoi_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output ftoi_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [1:0]         csr_data
);
   import ftoi_pkg::*;

   mode_type mode_ff;
   logic     sbytes_ff;
   logic     vin_ff, vout_ff;
   req_type  req_ff;
   rsp_type  rsp_ff, rsp_in;

   assign req_busy  = 1'b0;
   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BYTE;
         sbytes_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_OUT_MODE) mode_ff <= mode_type'(csr_data);
         else sbytes_ff <= csr_data[0];
      end
   end

   // datapath: floor(2x) as magnitude + fraction, then offset, halve, clamp
   logic        neg, frac, big, nan, inf, sbyte;
   logic [7:0]  ex;
   logic [23:0] m;
   logic [40:0] sh_full;
   logic [17:0] mag;     // floor(2|x|) when not big
   logic signed [20:0] t, v, lo, hi;
   logic [8:0]  sh;
   logic [4:0]  k;
   logic [23:0] mask;

   always_comb begin
      ex    = req_ff.sample_bits[30:23];
      neg   = req_ff.sample_bits[31];
      m     = {ex != 8'd0, req_ff.sample_bits[22:0]};
      nan   = (ex == 8'hFF) && (req_ff.sample_bits[22:0] != 23'd0);
      inf   = (ex == 8'hFF) && !nan;
      sbyte = (mode_ff == MODE_BYTE) && sbytes_ff;
      sh    = {1'b0, (ex == 8'd0) ? 8'd1 : ex};
      frac  = 1'b0;
      sh_full = '0;
      k     = '0;
      mask  = '0;
      if (sh >= 9'd149) begin
         sh_full = {17'd0, m} << (sh - 9'd149);
      end else if (sh <= 9'd124) begin
         frac = m != 24'd0;
      end else begin
         k       = 5'(9'd149 - sh);
         sh_full = {17'd0, m >> k};
         mask    = (24'd1 << k) - 24'd1;
         frac    = (m & mask) != 24'd0;
      end
      // anything past 18 bits lies far outside every output range
      big   = (sh > 9'd165) || (sh_full[40:18] != 23'd0);
      mag   = sh_full[17:0];
      if (big) t = neg ? -21'sd131072 * 2 : 21'sd262143;
      else if (neg) t = -$signed({3'b0, mag}) - (frac ? 21'sd1 : 21'sd0);
      else t = $signed({3'b0, mag});
      t = sbyte ? t - 21'sd255 : t + 21'sd1;
      v = t >>> 1;
      unique case (mode_ff)
         MODE_BYTE:   begin lo = sbyte ? -21'sd128 : 21'sd0; hi = sbyte ? 21'sd127 : 21'sd255; end
         MODE_SSHORT: begin lo = -21'sd32768; hi = 21'sd32767; end
         default:     begin lo = 21'sd0; hi = 21'sd65535; end
      endcase
      rsp_in.last_out = req_ff.last_in_line;
      rsp_in.clipped  = 1'b0;
      if (inf) begin
         v = neg ? lo : hi;
         rsp_in.clipped = 1'b1;
      end else if (v < lo) begin
         v = lo; rsp_in.clipped = 1'b1;
      end else if (v > hi) begin
         v = hi; rsp_in.clipped = 1'b1;
      end
      rsp_in.converted = (mode_ff == MODE_BYTE) ? {8'd0, v[7:0]} : v[15:0];
      if (mode_ff == MODE_NONE) begin
         rsp_in.converted = '0; rsp_in.clipped = 1'b0;
      end else if (nan) begin
         rsp_in.converted = '0; rsp_in.clipped = 1'b1;
      end
   end

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vin_ff  <= 1'b0;
         vout_ff <= 1'b0;
      end else begin
         vin_ff  <= req_start;
         vout_ff <= vin_ff;
      end
      if (req_start) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vout_ff;
   assign rsp_data   = rsp_ff;

   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_start |=> ##1 rsp_strobe) else $error("result missing");
   a_none: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && mode_ff == MODE_NONE && $past(mode_ff) == MODE_NONE
      |-> !rsp_data.clipped) else $error("unused mode clipped");
   a_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && mode_ff == MODE_BYTE && $past(mode_ff) == MODE_BYTE
      |-> rsp_data.converted[15:8] == 8'd0) else $error("byte high bits");
endmodule

// ===== dv/float_to_int_saturating_convert_tb.sv =====
// Testbench for float_to_int_saturating_convert: directed and random float32 samples
// in every output mode, checked against a bit-exact predictor. Depends on ftoi_pkg.
`timescale 1ns / 100ps

module float_to_int_saturating_convert_tb;
   import ftoi_pkg::*;

   // expected conversions, oldest first
   class conv_scoreboard;
      rsp_type pending[$];
      int      errors = 0;
      mode_type mode = MODE_BYTE;
      logic     sbytes = 1'b0;

      // floor(2*x) for a finite float, saturated
      function longint floor_twice(logic [31:0] b);
         logic [7:0]  ex;
         logic [23:0] m;
         int          sh;
         longint      mag;
         logic        frac;
         ex = b[30:23];
         m = {1'b0, b[22:0]};
         frac = 1'b0;
         if (ex != 0) m[23] = 1'b1; else ex = 8'd1;
         sh = int'(ex) - 149;
         if (sh >= 0) begin
            if (sh > 16) mag = 64'sd1 << 40;
            else mag = longint'(m) << sh;
         end else if (-sh >= 25) begin
            mag = 0;
            frac = (m != 0);
         end else begin
            mag = longint'(m >> (-sh));
            frac = ((m & ((24'd1 << (-sh)) - 1)) != 0);
         end
         if (!b[31]) return mag;
         return -mag - (frac ? 1 : 0);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         logic [31:0] b;
         logic        sb;
         longint      lo, hi, t, v;
         b = r.sample_bits;
         sb = (mode == MODE_BYTE) && sbytes;
         e.last_out = r.last_in_line;
         e.converted = 16'd0;
         e.clipped = 1'b0;
         if (mode == MODE_NONE) begin
         end else if (b[30:23] == 8'hFF && b[22:0] != 0) begin
            e.clipped = 1'b1;
         end else begin
            case (mode)
               MODE_BYTE: begin
                  if (sb) begin lo = -128; hi = 127; end else begin lo = 0; hi = 255; end
               end
               MODE_SSHORT: begin lo = -32768; hi = 32767; end
               default: begin lo = 0; hi = 65535; end
            endcase
            if (b[30:23] == 8'hFF) begin
               v = b[31] ? lo : hi;
               e.clipped = 1'b1;
            end else begin
               t = floor_twice(b) + (sb ? -255 : 1);
               v = t >>> 1;   // arithmetic shift is floor division by two
               if (v < lo) begin v = lo; e.clipped = 1'b1; end
               if (v > hi) begin v = hi; e.clipped = 1'b1; end
            end
            e.converted = (mode == MODE_BYTE) ? {8'd0, v[7:0]} : v[15:0];
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.converted !== e.converted) begin
            $error("converted: expected %h actual %h", e.converted, a.converted);
            errors++;
         end
         if (a.clipped !== e.clipped) begin
            $error("clipped: expected %b actual %b", e.clipped, a.clipped);
            errors++;
         end
         if (a.last_out !== e.last_out) begin
            $error("last_out: expected %b actual %b", e.last_out, a.last_out);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_start = 1'b0;
   logic    req_busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = 1'b0;
   logic [1:0] csr_data = 2'd0;

   conv_scoreboard sb = new();

   float_to_int_saturating_convert dut (.*);

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
   end

   task automatic write_reg(logic idx, logic [1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OUT_MODE) sb.mode = mode_type'(val);
      else sb.sbytes = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one request with a random lead gap
   task automatic send_sample(logic [31:0] bits, logic last);
      int gap;
      req_type r;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) begin
         @(negedge clock);
         req_start <= 1'b0;
      end
      @(negedge clock);
      r.sample_bits = bits;
      r.last_in_line = last;
      req_start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_busy);
      sb.note_request(r);
   endtask

   task automatic drain;
      @(negedge clock);
      req_start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_sample();
      logic [31:0] b;
      b = $urandom;
      case ($urandom_range(0, 5))
         0, 1: b[30:23] = 8'(8'd118 + $urandom_range(0, 25));   // near unit range
         2: b[30:23] = 8'(8'd126 + $urandom_range(0, 18));      // around limits
         3: b[22:0] = b[22:0] & 23'h7;                          // near half points
         default: ;
      endcase
      return b;
   endfunction

   logic [31:0] directed[] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
      32'h3EFF_FFFF, 32'h3F00_0000, 32'hBF00_0000, 32'h437F_0000, 32'h437F_8000,
      32'h4300_0000, 32'h42FF_0000, 32'h477F_FF00, 32'h4700_0000, 32'hC700_0080,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF,
      32'hFF7F_FFFF};

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed pass over every mode setting
      for (int m = 0; m < 4; m++) begin
         for (int s = 0; s < 2; s++) begin
            write_reg(CSR_OUT_MODE, m[1:0]);
            write_reg(CSR_SIGNED_BYTES, s[0]);
            foreach (directed[i]) send_sample(directed[i], i[0]);
            drain();
         end
      end
      // random phases
      for (int p = 0; p < 18; p++) begin
         write_reg(CSR_OUT_MODE, (p < 2) ? 2'd0 : 2'($urandom_range(0, 3)));
         write_reg(CSR_SIGNED_BYTES, (p < 2) ? p[0] : 1'($urandom));
         for (int i = 0; i < 100; i++) begin
            send_sample(rand_sample(), 1'($urandom));
            if (i == 50 && p == 3) begin
               // pause until every pending result has come back
               @(negedge clock);
               req_start <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/ftoi_pkg.sv
rtl/float_to_int_saturating_convert.sv
dv/float_to_int_saturating_convert_tb.sv
